@@ hw/rtl/tws_pkg.sv @@
package tws_pkg;

    localparam int DIVIDEND_W = 17;
    localparam int DIVISOR_W  = 16;
    localparam int SLOT_W     = 10;
    localparam int ROUND_W    = 22;
    localparam int TICKS_W    = 16;
    localparam int SIZE_W     = 11;
    localparam int ENTRY_W    = 1 + TICKS_W + SLOT_W + ROUND_W;

    localparam logic [SIZE_W-1:0] SIZE_MAX = 11'd1024;

    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_REG     = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam logic ADDR_TICK_PERIOD = 1'b0;
    localparam logic ADDR_SLOT_COUNT  = 1'b1;

    typedef enum logic [2:0] {
        KIND_FIRED      = 3'd0,
        KIND_REGISTERED = 3'd1,
        KIND_FULL       = 3'd2,
        KIND_TICK_DONE  = 3'd3,
        KIND_RESTARTED  = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADV,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_FIRE,
        ST_RS_WAIT,
        ST_DONE,
        ST_FIND,
        ST_TDIV,
        ST_PSTART,
        ST_PDIV,
        ST_REMIT,
        ST_FULL,
        ST_RST,
        ST_RST_EMIT
    } state_t;

    typedef struct packed {
        logic                rep;
        logic [TICKS_W-1:0]  ticks;
        logic [SLOT_W-1:0]   slot;
        logic [ROUND_W-1:0]  round;
    } entry_t;

    typedef struct packed {
        logic  ld_in;
        logic  pos_adv;
        logic  pos_clr;
        logic  idx_clr;
        logic  idx_inc;
        logic  div_start;
        logic  div_sel;
        logic  ld_ticks_q;
        logic  ld_ticks_mem;
        logic  mem_we;
        logic  set_valid;
        logic  clr_valid;
        logic  emit;
        kind_t emit_kind;
        logic  emit_use_idx;
        logic  emit_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic out_free;
        logic idx_last;
        logic cur_valid;
        logic match;
        logic rep;
    } dp_status_t;

endpackage

@@ hw/rtl/tws_ram.sv @@
module tws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/tws_div.sv @@
module tws_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [tws_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [tws_pkg::DIVISOR_W-1:0]    divisor,
    output logic                             busy,
    output logic                             done,
    output logic [tws_pkg::DIVIDEND_W-1:0]   quotient,
    output logic [tws_pkg::DIVISOR_W-1:0]    remainder
);

    localparam int CNT_W = $clog2(tws_pkg::DIVIDEND_W + 1);

    logic [tws_pkg::DIVIDEND_W-1:0] rem_reg, rem_next;
    logic [tws_pkg::DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [tws_pkg::DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [tws_pkg::DIVIDEND_W-1:0] shifted;
    logic [tws_pkg::DIVIDEND_W-1:0] dvs_ext;

    assign shifted = {rem_reg[tws_pkg::DIVIDEND_W-2:0], quo_reg[tws_pkg::DIVIDEND_W-1]};
    assign dvs_ext = {{(tws_pkg::DIVIDEND_W - tws_pkg::DIVISOR_W){1'b0}}, dvs_reg};

    // one restoring step per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(tws_pkg::DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= dvs_ext)
            begin
                rem_next = shifted - dvs_ext;
                quo_next = {quo_reg[tws_pkg::DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[tws_pkg::DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[tws_pkg::DIVISOR_W-1:0];

endmodule

@@ hw/rtl/tws_ctrl.sv @@
module tws_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [1:0]             mode,
    output logic                   in_stall,
    input  tws_pkg::dp_status_t    status,
    output tws_pkg::ctrl_cmd_t     cmd
);

    tws_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tws_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode)
                        tws_pkg::MODE_TICK:    state_next = tws_pkg::ST_ADV;
                        tws_pkg::MODE_REG:     state_next = tws_pkg::ST_FIND;
                        tws_pkg::MODE_RESTART: state_next = tws_pkg::ST_RST;
                        default:               state_next = tws_pkg::ST_IDLE;
                    endcase
                end
            end
            tws_pkg::ST_ADV:     state_next = tws_pkg::ST_SCAN_RD;
            tws_pkg::ST_SCAN_RD: state_next = tws_pkg::ST_SCAN_CHK;
            tws_pkg::ST_SCAN_CHK:
            begin
                if (status.match)
                    state_next = tws_pkg::ST_FIRE;
                else if (status.idx_last)
                    state_next = tws_pkg::ST_DONE;
                else
                    state_next = tws_pkg::ST_SCAN_RD;
            end
            tws_pkg::ST_FIRE:
            begin
                if (status.out_free)
                begin
                    if (status.rep)
                        state_next = tws_pkg::ST_RS_WAIT;
                    else if (status.idx_last)
                        state_next = tws_pkg::ST_DONE;
                    else
                        state_next = tws_pkg::ST_SCAN_RD;
                end
            end
            tws_pkg::ST_RS_WAIT:
            begin
                if (status.div_done)
                    state_next = status.idx_last ? tws_pkg::ST_DONE : tws_pkg::ST_SCAN_RD;
            end
            tws_pkg::ST_DONE:
            begin
                if (status.out_free)
                    state_next = tws_pkg::ST_IDLE;
            end
            tws_pkg::ST_FIND:
            begin
                if (!status.cur_valid)
                    state_next = tws_pkg::ST_TDIV;
                else if (status.idx_last)
                    state_next = tws_pkg::ST_FULL;
            end
            tws_pkg::ST_TDIV:
            begin
                if (status.div_done)
                    state_next = tws_pkg::ST_PSTART;
            end
            tws_pkg::ST_PSTART: state_next = tws_pkg::ST_PDIV;
            tws_pkg::ST_PDIV:
            begin
                if (status.div_done)
                    state_next = tws_pkg::ST_REMIT;
            end
            tws_pkg::ST_REMIT, tws_pkg::ST_FULL, tws_pkg::ST_RST_EMIT:
            begin
                if (status.out_free)
                    state_next = tws_pkg::ST_IDLE;
            end
            tws_pkg::ST_RST: state_next = tws_pkg::ST_RST_EMIT;
            default:         state_next = tws_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.emit_kind = tws_pkg::KIND_FIRED;
        in_stall      = 1'b1;
        case (state_reg)
            tws_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.ld_in   = in_valid;
                cmd.idx_clr = in_valid;
            end
            tws_pkg::ST_ADV: cmd.pos_adv = 1'b1;
            tws_pkg::ST_SCAN_CHK:
            begin
                cmd.ld_ticks_mem = status.match;
                cmd.idx_inc      = !status.match && !status.idx_last;
            end
            tws_pkg::ST_FIRE:
            begin
                if (status.out_free)
                begin
                    cmd.emit         = 1'b1;
                    cmd.emit_kind    = tws_pkg::KIND_FIRED;
                    cmd.emit_use_idx = 1'b1;
                    cmd.div_start    = status.rep;
                    cmd.div_sel      = 1'b1;
                    cmd.clr_valid    = !status.rep;
                    cmd.idx_inc      = !status.rep && !status.idx_last;
                end
            end
            tws_pkg::ST_RS_WAIT:
            begin
                cmd.mem_we  = status.div_done;
                cmd.idx_inc = status.div_done && !status.idx_last;
            end
            tws_pkg::ST_DONE:
            begin
                cmd.emit      = status.out_free;
                cmd.emit_kind = tws_pkg::KIND_TICK_DONE;
                cmd.emit_last = 1'b1;
            end
            tws_pkg::ST_FIND:
            begin
                cmd.div_start = !status.cur_valid;
                cmd.idx_inc   = status.cur_valid && !status.idx_last;
            end
            tws_pkg::ST_TDIV: cmd.ld_ticks_q = status.div_done;
            tws_pkg::ST_PSTART:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
            end
            tws_pkg::ST_PDIV:
            begin
                cmd.mem_we    = status.div_done;
                cmd.set_valid = status.div_done;
            end
            tws_pkg::ST_REMIT:
            begin
                cmd.emit         = status.out_free;
                cmd.emit_kind    = tws_pkg::KIND_REGISTERED;
                cmd.emit_use_idx = 1'b1;
                cmd.emit_last    = 1'b1;
            end
            tws_pkg::ST_FULL:
            begin
                cmd.emit      = status.out_free;
                cmd.emit_kind = tws_pkg::KIND_FULL;
                cmd.emit_last = 1'b1;
            end
            tws_pkg::ST_RST: cmd.pos_clr = 1'b1;
            tws_pkg::ST_RST_EMIT:
            begin
                cmd.emit      = status.out_free;
                cmd.emit_kind = tws_pkg::KIND_RESTARTED;
                cmd.emit_last = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tws_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("emit while output register is occupied");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");
    a_we_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_we |-> status.div_done)
        else $error("entry written without a finished divide");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> state_reg == tws_pkg::ST_IDLE)
        else $error("input taken outside idle");
`endif

endmodule

@@ hw/rtl/tws_dp.sv @@
module tws_dp #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    input  logic [15:0]            interval,
    input  logic                   recurring,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             kind,
    output logic [3:0]             timer_id,
    output logic [31:0]            abs_slot,
    output logic                   last,
    input  tws_pkg::ctrl_cmd_t     cmd,
    output tws_pkg::dp_status_t    status
);

    localparam int IW = $clog2(NUM_TIMERS);

    logic [15:0]                   tick_period_reg;
    logic [tws_pkg::SIZE_W-1:0]    slot_count_reg;
    logic [tws_pkg::SLOT_W-1:0]    slot_reg;
    logic [tws_pkg::ROUND_W-1:0]   round_reg;
    logic [NUM_TIMERS-1:0]         valid_reg;
    logic [IW-1:0]                 idx_reg;
    logic [15:0]                   interval_reg;
    logic                          rec_reg;
    logic [tws_pkg::TICKS_W-1:0]   ticks_reg;
    logic                          out_valid_reg;
    logic [2:0]                    kind_reg;
    logic [3:0]                    id_reg;
    logic [31:0]                   abs_reg;
    logic                          last_reg;

    logic [tws_pkg::SIZE_W-1:0]    size;
    logic [15:0]                   tp_eff;
    logic [tws_pkg::SIZE_W-1:0]    slot_inc;
    logic [32:0]                   prod;
    logic [31:0]                   abs_now;
    logic                          cfg_we;
    logic                          out_free;

    logic [tws_pkg::DIVIDEND_W-1:0] div_dividend;
    logic [tws_pkg::DIVISOR_W-1:0]  div_divisor;
    logic                           div_busy;
    logic                           div_done;
    logic [tws_pkg::DIVIDEND_W-1:0] div_q;
    logic [tws_pkg::DIVISOR_W-1:0]  div_r;

    tws_pkg::entry_t               rd_entry;
    tws_pkg::entry_t               wr_entry;
    logic [tws_pkg::ENTRY_W-1:0]   rd_bits;
    logic [IW+3:0]                 id_wide;

    // clamp the configuration to its usable range
    assign size = (slot_count_reg == '0) ? tws_pkg::SIZE_W'(1) :
                  (slot_count_reg > tws_pkg::SIZE_MAX) ? tws_pkg::SIZE_MAX : slot_count_reg;
    assign tp_eff = (tick_period_reg == '0) ? 16'd1 : tick_period_reg;

    assign prod    = 33'(round_reg) * 33'(size);
    assign abs_now = prod[31:0] + {{(32 - tws_pkg::SLOT_W){1'b0}}, slot_reg};

    assign slot_inc = {1'b0, slot_reg} + tws_pkg::SIZE_W'(1);

    assign cfg_we = psel && penable && pwrite;
    always_comb
    begin
        case (paddr[2])
            tws_pkg::ADDR_TICK_PERIOD: prdata = {16'd0, tick_period_reg};
            tws_pkg::ADDR_SLOT_COUNT:  prdata = {21'd0, slot_count_reg};
            default:                   prdata = '0;
        endcase
    end

    // divide interval by tick period, or slot offset by wheel size
    assign div_dividend = cmd.div_sel ?
        (tws_pkg::DIVIDEND_W'(slot_reg) + tws_pkg::DIVIDEND_W'(ticks_reg)) :
        {1'b0, interval_reg};
    assign div_divisor = cmd.div_sel ? tws_pkg::DIVISOR_W'(size) : tp_eff;

    tws_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign wr_entry.rep   = rec_reg;
    assign wr_entry.ticks = ticks_reg;
    assign wr_entry.slot  = div_r[tws_pkg::SLOT_W-1:0];
    assign wr_entry.round = round_reg + tws_pkg::ROUND_W'(div_q);

    tws_ram #(
        .WIDTH (tws_pkg::ENTRY_W),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.mem_we),
        .waddr (idx_reg),
        .wdata (wr_entry),
        .raddr (idx_reg),
        .rdata (rd_bits)
    );
    assign rd_entry = rd_bits;

    assign out_free = !out_valid_reg || !out_stall;
    assign id_wide  = {4'd0, idx_reg};

    assign status.div_busy  = div_busy;
    assign status.div_done  = div_done;
    assign status.out_free  = out_free;
    assign status.idx_last  = (idx_reg == IW'(NUM_TIMERS - 1));
    assign status.cur_valid = valid_reg[idx_reg];
    assign status.match     = valid_reg[idx_reg] && (rd_entry.slot == slot_reg) &&
                              (rd_entry.round == round_reg);
    assign status.rep       = rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg <= 16'd1;
            slot_count_reg  <= tws_pkg::SIZE_W'(16);
            slot_reg        <= '0;
            round_reg       <= '0;
            valid_reg       <= '0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (paddr[2])
                    tws_pkg::ADDR_TICK_PERIOD: tick_period_reg <= pwdata[15:0];
                    tws_pkg::ADDR_SLOT_COUNT:  slot_count_reg  <= pwdata[tws_pkg::SIZE_W-1:0];
                    default:                   tick_period_reg <= tick_period_reg;
                endcase
            end
            if (cmd.pos_clr)
            begin
                slot_reg  <= '0;
                round_reg <= '0;
            end
            else if (cmd.pos_adv)
            begin
                if (slot_inc >= size)
                begin
                    slot_reg  <= '0;
                    round_reg <= round_reg + 1'b1;
                end
                else
                begin
                    slot_reg <= slot_inc[tws_pkg::SLOT_W-1:0];
                end
            end
            if (cmd.set_valid)
                valid_reg[idx_reg] <= 1'b1;
            else if (cmd.clr_valid)
                valid_reg[idx_reg] <= 1'b0;
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            interval_reg <= interval;
            rec_reg      <= recurring;
        end
        else if (cmd.ld_ticks_mem)
        begin
            rec_reg <= rd_entry.rep;
        end
        if (cmd.ld_ticks_mem)
            ticks_reg <= rd_entry.ticks;
        else if (cmd.ld_ticks_q)
            ticks_reg <= (div_q[15:0] == '0) ? 16'd1 : div_q[15:0];
        if (cmd.emit)
        begin
            kind_reg <= cmd.emit_kind;
            id_reg   <= cmd.emit_use_idx ? id_wide[3:0] : 4'd0;
            abs_reg  <= abs_now;
            last_reg <= cmd.emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign timer_id  = id_reg;
    assign abs_slot  = abs_reg;
    assign last      = last_reg;

endmodule

@@ hw/rtl/timing_wheel_scheduler.sv @@
// Hashed timing wheel with rounds over a table of NUM_TIMERS timer entries.
// Input channel (in_valid/in_stall) carries mode, interval and recurring; a
// beat is taken only while the block is idle. Output channel (out_valid/
// out_stall) carries kind, timer_id, abs_slot and last; last marks the final
// beat caused by one input beat.
// Register beat: scan valid bits for a free entry (one entry a cycle),
// divide interval by tick_period in the shared restoring divider, place the
// entry by a second divide by the wheel size and return one beat, or a full
// beat if no entry is free.
// Tick beat: advance the wheel, then scan the entry RAM entry by entry
// (registered read, then compare). A one-shot fire returns a beat and clears
// the entry; a recurring fire returns a beat and re-places it by a divide.
// Restart clears the wheel position; mode 3 is taken and dropped.
// Results sit in one output register; a stalled receiver holds the current
// beat and the sequencer waits for it before writing the next one.
// Reset clears the valid bits, the wheel position and the configuration
// (tick_period 1, slot_count 16); entry contents stay undefined until written.
// Configuration is an APB port, tick_period at 0x0 and slot_count at 0x4.
module timing_wheel_scheduler #(
    parameter int NUM_TIMERS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [15:0] interval,
    input  logic        recurring,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [3:0]  timer_id,
    output logic [31:0] abs_slot,
    output logic        last
);

    tws_pkg::ctrl_cmd_t  cmd;
    tws_pkg::dp_status_t status;

    // writes always complete in the access cycle
    assign pready = 1'b1;

    // sequencer: owns the scan order and the handshake on the input side
    tws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: wheel position, entry table, divider and output register
    tws_dp #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .interval  (interval),
        .recurring (recurring),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .timer_id  (timer_id),
        .abs_slot  (abs_slot),
        .last      (last),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
